[rtl/mtflru_pkg.sv]
// Shared package for the move-to-front LRU tag store.
// Holds sizing constants, the controller state type and the control struct.
// No dependencies.
package mtflru_pkg;

	localparam int ENTRIES    = 32;
	localparam int KEY_W      = 64;
	localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OUT_SLOT_W = 5;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic capture;
		logic commit;
	} ctrl_t;

endpackage

[rtl/move_to_front_lru_cache.sv]
// Top level of the move-to-front LRU tag store: a chain of tag cells, the
// sequencer and the result register. Depends on mtflru_pkg, mtflru_cell and
// mtflru_ctrl.
//
// A lookup registers the key on the accepted beat, then compares every cell
// in parallel, then walks the first-match chain, shifts the row and loads the
// result into the output register once that register is free. A new beat is
// accepted while an earlier result still waits on the output side. Reset
// leaves every entry invalid, with position i owning slot i.
module move_to_front_lru_cache (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] lookup_key
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] hit, [5:1] slot, [6] evict_live, [7] zero
);

	localparam int N   = mtflru_pkg::ENTRIES;
	localparam int SW  = mtflru_pkg::SLOT_W;
	localparam int OSW = mtflru_pkg::OUT_SLOT_W;

	mtflru_pkg::ctrl_t ctrl;

	logic [mtflru_pkg::KEY_W-1:0] key_q;
	logic                         m_tvalid_q;
	logic [mtflru_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                         out_free;

	logic [mtflru_pkg::KEY_W-1:0] cell_key   [N];
	logic                         cell_valid [N];
	logic [SW-1:0]                cell_slot  [N];
	logic                         found_c    [N+1];
	logic [SW-1:0]                slot_c     [N+1];

	logic                         res_hit;
	logic [SW-1:0]                res_slot;
	logic                         res_live;
	logic [SW+OSW-1:0]            slot_ext;

	assign out_free = !m_tvalid_q || m_tready;

	mtflru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	assign s_tready = ctrl.in_ready;

	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.in_ready) begin
			key_q <= s_tdata;
		end
	end

	assign found_c[0] = 1'b0;
	assign slot_c[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [mtflru_pkg::KEY_W-1:0] pk;
		logic                         pv;
		logic [SW-1:0]                ps;

		if (i == 0) begin : g_head
			assign pk = key_q;
			assign pv = 1'b1;
			assign ps = res_slot;
		end else begin : g_body
			assign pk = cell_key[i-1];
			assign pv = cell_valid[i-1];
			assign ps = cell_slot[i-1];
		end

		mtflru_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.index      (SW'(i)),
			.lookup_key (key_q),
			.capture    (ctrl.capture),
			.commit     (ctrl.commit),
			.prev_key   (pk),
			.prev_valid (pv),
			.prev_slot  (ps),
			.found_in   (found_c[i]),
			.slot_in    (slot_c[i]),
			.key        (cell_key[i]),
			.valid      (cell_valid[i]),
			.slot       (cell_slot[i]),
			.found_out  (found_c[i+1]),
			.slot_out   (slot_c[i+1])
		);
	end

	assign res_hit  = found_c[N];
	assign res_slot = slot_c[N];
	assign res_live = !res_hit && cell_valid[N-1];
	assign slot_ext = {{OSW{1'b0}}, res_slot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			m_tdata_q <= {1'b0, res_live, slot_ext[OSW-1:0], res_hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |-> !ctrl.commit)
		else $error("result register overwritten while a beat is pending");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat accepted during a lookup");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.commit |=> cell_valid[0])
		else $error("front entry not valid after an update");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[6]))
		else $error("hit reported together with a live eviction");
`endif

endmodule

[rtl/mtflru_cell.sv]
// One position of the recency-ordered tag store: key, valid bit and owned slot.
// Compares its key, passes the first-match flag and slot down the chain, and
// takes its neighbor's entry when the row shifts. Depends on mtflru_pkg.
module mtflru_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mtflru_pkg::SLOT_W-1:0] index,
	input  logic [mtflru_pkg::KEY_W-1:0]  lookup_key,
	input  logic                         capture,
	input  logic                         commit,
	input  logic [mtflru_pkg::KEY_W-1:0]  prev_key,
	input  logic                         prev_valid,
	input  logic [mtflru_pkg::SLOT_W-1:0] prev_slot,
	input  logic                         found_in,
	input  logic [mtflru_pkg::SLOT_W-1:0] slot_in,
	output logic [mtflru_pkg::KEY_W-1:0]  key,
	output logic                         valid,
	output logic [mtflru_pkg::SLOT_W-1:0] slot,
	output logic                         found_out,
	output logic [mtflru_pkg::SLOT_W-1:0] slot_out
);

	logic [mtflru_pkg::KEY_W-1:0]  key_q;
	logic                         valid_q;
	logic [mtflru_pkg::SLOT_W-1:0] slot_q;
	logic                         match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			valid_q <= 1'b0;
			slot_q  <= index;
			match_q <= 1'b0;
		end else begin
			if (capture) begin
				match_q <= valid_q && (key_q == lookup_key);
			end
			if (commit && !found_in) begin
				key_q   <= prev_key;
				valid_q <= prev_valid;
				slot_q  <= prev_slot;
			end
		end
	end

	assign found_out = found_in | match_q;
	assign slot_out  = found_in ? slot_in : slot_q;
	assign key       = key_q;
	assign valid     = valid_q;
	assign slot      = slot_q;

endmodule

[rtl/mtflru_ctrl.sv]
// Sequencer for one lookup: accept, compare, then update and load the result.
// Depends on mtflru_pkg for the state type and control struct.
module mtflru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	output mtflru_pkg::ctrl_t  ctrl
);

	mtflru_pkg::state_t state_q;
	mtflru_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtflru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtflru_pkg::ST_IDLE: begin
				if (in_valid) state_d = mtflru_pkg::ST_CMP;
			end
			mtflru_pkg::ST_CMP: begin
				state_d = mtflru_pkg::ST_UPD;
			end
			mtflru_pkg::ST_UPD: begin
				if (out_free) state_d = mtflru_pkg::ST_IDLE;
			end
			default: begin
				state_d = mtflru_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			mtflru_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
			mtflru_pkg::ST_CMP:  ctrl.capture  = 1'b1;
			mtflru_pkg::ST_UPD:  ctrl.commit   = out_free;
			default:             ctrl = '0;
		endcase
	end

endmodule
